// ===== rtl/ultrasonic_range_guard_top_macros.svh =====
// Assertion helpers shared by the checker.
`ifndef ULTRASONIC_RANGE_GUARD_TOP_MACROS_SVH
`define ULTRASONIC_RANGE_GUARD_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define URG_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ultrasonic range guard: assertion failed");

// Next-cycle implication, disabled during reset.
`define URG_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ultrasonic range guard: assertion failed");

`endif

// ===== rtl/urg_pkg.sv =====
`default_nettype none

package urg_pkg;

   localparam int unsigned CFG_WIDTH  = 20;
   localparam int unsigned CSR_IDX_W  = 3;

   // register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD_CM = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_CM       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TICKS_PER_CM = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ECHO_TIMEOUT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_GAP_TICKS    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SWEEP_STEP   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_SWEEP_LIMIT  = 3'd6;

   // reset values of the registers
   localparam logic [9:0]  RST_THRESHOLD_CM = 10'd40;
   localparam logic [9:0]  RST_MAX_CM       = 10'd1000;
   localparam logic [7:0]  RST_TICKS_PER_CM = 8'd58;
   localparam logic [19:0] RST_ECHO_TIMEOUT = 20'd500000;
   localparam logic [19:0] RST_GAP_TICKS    = 20'd100000;
   localparam logic [3:0]  RST_SWEEP_STEP   = 4'd5;
   localparam logic [4:0]  RST_SWEEP_LIMIT  = 5'd10;

   localparam logic [10:0] CM_COUNT_MAX = 11'd2047;

   typedef struct packed {
      logic              echo_level;
      logic signed [7:0] steer_angle;
   } req_type;

   typedef struct packed {
      logic              trig_level;
      logic signed [7:0] servo_angle;
      logic [9:0]        distance_cm;
      logic              reading_done;
      logic              reading_rejected;
      logic              near_flag;
   } rsp_type;

   typedef struct packed {
      logic [9:0]  threshold_cm;
      logic [9:0]  max_cm;
      logic [7:0]  ticks_per_cm;
      logic [19:0] echo_timeout_ticks;
      logic [19:0] gap_ticks;
      logic [3:0]  sweep_step;
      logic [4:0]  sweep_limit;
   } cfg_type;

   typedef struct packed {
      logic signed [5:0] offset;
      logic              up;
   } sweep_type;

   typedef enum logic [5:0] {
      PH_START     = 6'b000001,
      PH_TRIG_LOW  = 6'b000010,
      PH_TRIG_HIGH = 6'b000100,
      PH_WAIT_RISE = 6'b001000,
      PH_MEASURE   = 6'b010000,
      PH_GAP       = 6'b100000
   } phase_type;

endpackage

`default_nettype wire

// ===== rtl/urg_servo.sv =====
`default_nettype none

// Servo command for the start of a measurement cycle, with sweep update.
module urg_servo
   import urg_pkg::*;
(
   input  wire logic signed [7:0] steer_angle,
   input  wire logic              near_state,
   input  wire sweep_type         sweep,
   input  wire cfg_type           cfg,
   output logic signed [7:0]      servo_angle,
   output sweep_type              sweep_next
);

   logic              sweep_en;
   logic signed [6:0] step_s;
   logic signed [6:0] lim_s;
   logic signed [6:0] sum;
   logic signed [6:0] off_c;
   logic signed [8:0] angle_sum;

   always_comb begin
      sweep_en = (steer_angle == 8'sd0) && !near_state;
      step_s   = $signed({3'b000, cfg.sweep_step});
      lim_s    = $signed({2'b00, cfg.sweep_limit});
      sum      = $signed({sweep.offset[5], sweep.offset}) + (sweep.up ? step_s : -step_s);

      // offset saturates to 6-bit signed before the reversal test
      if (sum > 7'sd31) begin
         off_c = 7'sd31;
      end else if (sum < -7'sd32) begin
         off_c = -7'sd32;
      end else begin
         off_c = sum;
      end

      sweep_next = sweep;
      if (sweep_en) begin
         sweep_next.offset = off_c[5:0];
         if ((off_c >= lim_s) || (off_c <= -lim_s)) begin
            sweep_next.up = !sweep.up;
         end
      end

      if (sweep_en) begin
         angle_sum = $signed({steer_angle[7], steer_angle})
                   + $signed({{3{off_c[6]}}, off_c[5:0]});
      end else begin
         angle_sum = $signed({steer_angle[7], steer_angle});
      end

      if (angle_sum > 9'sd127) begin
         servo_angle = 8'sd127;
      end else if (angle_sum < -9'sd127) begin
         servo_angle = -8'sd127;
      end else begin
         servo_angle = angle_sum[7:0];
      end
   end

endmodule

`default_nettype wire

// ===== rtl/urg_step.sv =====
`default_nettype none

// Measurement sequencer: state registers and one tick of next-state logic.
module urg_step
   import urg_pkg::*;
#(
   parameter int unsigned TRIG_LOW_TICKS   = 2,
   parameter int unsigned TRIG_HIGH_TICKS  = 20,
   parameter int unsigned TICK_COUNT_WIDTH = 20
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    advance,
   input  wire req_type req,
   input  wire cfg_type cfg,
   output rsp_type      rsp
);

   localparam int unsigned TW = TICK_COUNT_WIDTH;
   localparam int unsigned CW = (TW > CFG_WIDTH) ? TW : CFG_WIDTH;

   phase_type         phase_ff, phase_in;
   logic [TW-1:0]     phase_ticks_ff, phase_ticks_in;
   logic [TW-1:0]     pulse_ticks_ff, pulse_ticks_in;
   logic [7:0]        sub_cm_ff, sub_cm_in;
   logic [10:0]       cm_count_ff, cm_count_in;
   logic [9:0]        last_dist_ff, last_dist_in;
   logic              near_ff, near_in;
   sweep_type         sweep_ff, sweep_in;
   logic signed [7:0] servo_ff, servo_in;

   logic signed [7:0] servo_start;
   sweep_type         sweep_start;
   logic [CW-1:0]     tmo;
   logic [7:0]        tpc;
   logic              fin;
   logic              trig;
   logic              done;
   logic              rej;

   urg_servo u_servo (
      .steer_angle (req.steer_angle),
      .near_state  (near_ff),
      .sweep       (sweep_ff),
      .cfg         (cfg),
      .servo_angle (servo_start),
      .sweep_next  (sweep_start)
   );

   always_comb begin
      tmo = (cfg.echo_timeout_ticks == '0) ? CW'(1) : CW'(cfg.echo_timeout_ticks);
      tpc = (cfg.ticks_per_cm == 8'd0) ? 8'd1 : cfg.ticks_per_cm;

      phase_in       = phase_ff;
      phase_ticks_in = phase_ticks_ff;
      pulse_ticks_in = pulse_ticks_ff;
      sub_cm_in      = sub_cm_ff;
      cm_count_in    = cm_count_ff;
      last_dist_in   = last_dist_ff;
      near_in        = near_ff;
      sweep_in       = sweep_ff;
      servo_in       = servo_ff;
      fin            = 1'b0;
      trig           = 1'b0;
      done           = 1'b0;
      rej            = 1'b0;

      // the cycle-start tick is also the first trigger-low tick
      if (phase_in == PH_START) begin
         servo_in       = servo_start;
         sweep_in       = sweep_start;
         phase_in       = PH_TRIG_LOW;
         phase_ticks_in = '0;
      end

      case (phase_in)
         PH_TRIG_LOW: begin
            phase_ticks_in = phase_ticks_in + TW'(1);
            if (phase_ticks_in >= TW'(TRIG_LOW_TICKS)) begin
               phase_in       = PH_TRIG_HIGH;
               phase_ticks_in = '0;
            end
         end
         PH_TRIG_HIGH: begin
            trig           = 1'b1;
            phase_ticks_in = phase_ticks_in + TW'(1);
            if (phase_ticks_in >= TW'(TRIG_HIGH_TICKS)) begin
               phase_in       = PH_WAIT_RISE;
               phase_ticks_in = '0;
            end
         end
         PH_WAIT_RISE: begin
            if (req.echo_level) begin
               phase_in       = PH_MEASURE;
               pulse_ticks_in = '0;
               sub_cm_in      = '0;
               cm_count_in    = '0;
            end else begin
               phase_ticks_in = phase_ticks_in + TW'(1);
               // no echo: reading of zero
               if (CW'(phase_ticks_in) >= tmo) begin
                  cm_count_in = '0;
                  fin         = 1'b1;
               end
            end
         end
         PH_GAP: begin
            phase_ticks_in = phase_ticks_in + TW'(1);
            if (CW'(phase_ticks_in) >= CW'(cfg.gap_ticks)) begin
               phase_in       = PH_START;
               phase_ticks_in = '0;
            end
         end
         PH_MEASURE: begin
         end
         default: begin
            phase_in       = PH_START;
            phase_ticks_in = '0;
         end
      endcase

      if ((phase_in == PH_MEASURE) && !fin) begin
         if (!req.echo_level) begin
            fin = 1'b1;
         end else begin
            pulse_ticks_in = pulse_ticks_in + TW'(1);
            sub_cm_in      = sub_cm_in + 8'd1;
            if (sub_cm_in >= tpc) begin
               sub_cm_in = '0;
               if (cm_count_in < CM_COUNT_MAX) begin
                  cm_count_in = cm_count_in + 11'd1;
               end
            end
            if (CW'(pulse_ticks_in) >= tmo) begin
               fin = 1'b1;
            end
         end
      end

      if (fin) begin
         phase_ticks_in = '0;
         if (cm_count_in > {1'b0, cfg.max_cm}) begin
            phase_in = PH_START;
            rej      = 1'b1;
         end else begin
            last_dist_in = cm_count_in[9:0];
            near_in      = (cm_count_in[9:0] <= cfg.threshold_cm);
            phase_in     = (cfg.gap_ticks == '0) ? PH_START : PH_GAP;
            done         = 1'b1;
         end
      end

      rsp.trig_level       = trig;
      rsp.servo_angle      = servo_in;
      rsp.distance_cm      = last_dist_in;
      rsp.reading_done     = done;
      rsp.reading_rejected = rej;
      rsp.near_flag        = near_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_START;
         phase_ticks_ff <= '0;
         pulse_ticks_ff <= '0;
         sub_cm_ff      <= '0;
         cm_count_ff    <= '0;
         last_dist_ff   <= '0;
         near_ff        <= 1'b0;
         sweep_ff       <= '{offset: 6'sd0, up: 1'b1};
         servo_ff       <= 8'sd0;
      end else if (advance) begin
         phase_ff       <= phase_in;
         phase_ticks_ff <= phase_ticks_in;
         pulse_ticks_ff <= pulse_ticks_in;
         sub_cm_ff      <= sub_cm_in;
         cm_count_ff    <= cm_count_in;
         last_dist_ff   <= last_dist_in;
         near_ff        <= near_in;
         sweep_ff       <= sweep_in;
         servo_ff       <= servo_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/ultrasonic_range_guard_top.sv =====
// Ultrasonic range guard: drives an ultrasonic ranger and its servo.
// One req item is one microsecond tick: echo pin level and steering angle.
// Every accepted item gives exactly one rsp item: trigger level, servo
// command, last distance, reading done / rejected strobes and near flag.
// Channels: req_valid/req_stall in, rsp_valid/rsp_stall out; an item moves
// on a clock edge with valid high and stall low.
// Registers are written on the csr port (csr_valid and csr_ready, always
// ready) and should only be changed while no item is in flight.
// Path: an accepted item is registered in the input register, the
// sequencer works on it and the result lands in the output register,
// which drives rsp_valid and rsp_data.
// Throughput: one item per cycle unless rsp_stall holds the output.
// If rsp_stall is held the output register keeps its item, the input
// register fills behind it and req_stall rises; nothing is dropped.
// Reset (synchronous, active high) empties both registers, restores the
// register defaults and puts the sequencer at the start of a cycle.
`default_nettype none

module ultrasonic_range_guard_top
   import urg_pkg::*;
#(
   parameter int unsigned TRIG_LOW_TICKS   = 2,
   parameter int unsigned TRIG_HIGH_TICKS  = 20,
   parameter int unsigned TICK_COUNT_WIDTH = 20
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   // input item channel
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire req_type              req_data,
   // result item channel
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output rsp_type                   rsp_data,
   // register write port
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CFG_WIDTH-1:0] csr_wdata
);

   cfg_type cfg_ff, cfg_in;

   logic    in_valid_ff, in_valid_in;
   req_type in_data_ff;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_data_ff;
   rsp_type step_rsp;
   logic    advance;
   logic    accept;

   // --- register file ---
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_THRESHOLD_CM: cfg_in.threshold_cm       = csr_wdata[9:0];
            CSR_MAX_CM:       cfg_in.max_cm             = csr_wdata[9:0];
            CSR_TICKS_PER_CM: cfg_in.ticks_per_cm       = csr_wdata[7:0];
            CSR_ECHO_TIMEOUT: cfg_in.echo_timeout_ticks = csr_wdata[19:0];
            CSR_GAP_TICKS:    cfg_in.gap_ticks          = csr_wdata[19:0];
            CSR_SWEEP_STEP:   cfg_in.sweep_step         = csr_wdata[3:0];
            CSR_SWEEP_LIMIT:  cfg_in.sweep_limit        = csr_wdata[4:0];
            default: begin
               // unused index: ignored
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{threshold_cm:       RST_THRESHOLD_CM,
                     max_cm:             RST_MAX_CM,
                     ticks_per_cm:       RST_TICKS_PER_CM,
                     echo_timeout_ticks: RST_ECHO_TIMEOUT,
                     gap_ticks:          RST_GAP_TICKS,
                     sweep_step:         RST_SWEEP_STEP,
                     sweep_limit:        RST_SWEEP_LIMIT};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // --- handshake ---
   // the sequencer steps on a held item whenever the output register is free or emptying
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff <= step_rsp;
      end
   end

   // --- sequencer ---
   urg_step #(
      .TRIG_LOW_TICKS   (TRIG_LOW_TICKS),
      .TRIG_HIGH_TICKS  (TRIG_HIGH_TICKS),
      .TICK_COUNT_WIDTH (TICK_COUNT_WIDTH)
   ) u_step (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .req     (in_data_ff),
      .cfg     (cfg_ff),
      .rsp     (step_rsp)
   );

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

`default_nettype wire

// ===== rtl/urg_checker.sv =====
`default_nettype none

`include "ultrasonic_range_guard_top_macros.svh"

module urg_checker
   import urg_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_stall,
   input wire logic    rsp_valid,
   input wire logic    rsp_stall,
   input wire rsp_type rsp_data
);

   // a reading is either stored or dropped, never both
   `URG_ASSERT_NOW(a_done_xor_rej, clock, reset, rsp_valid,
                   !(rsp_data.reading_done && rsp_data.reading_rejected))

   // an empty output register never holds back the input side
   `URG_ASSERT_NOW(a_no_stall_when_empty, clock, reset, !rsp_valid, !req_stall)

   // the output register comes up empty after reset
   `URG_ASSERT_NOW(a_empty_after_reset, clock, reset, $past(reset), !rsp_valid)

   // a stalled result holds
   `URG_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
                    rsp_valid && $stable(rsp_data))

endmodule

bind ultrasonic_range_guard_top urg_checker u_urg_checker (.*);

`default_nettype wire

// ===== bench/ultrasonic_range_guard_top_test.sv =====
module ultrasonic_range_guard_top_test;
   import urg_pkg::*;

   // trigger timing of the block at its default parameters
   localparam int TRIG_LOW_TICKS  = 2;
   localparam int TRIG_HIGH_TICKS = 20;

   // generous bound on the whole run, in clock cycles
   localparam int CYCLE_LIMIT = 500000;

   // length of the one long receiver hold-off
   localparam int HOLD_OFF_CYCLES = 400;

   // csr index that selects no register
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 3'd7;

   // how a tick ended the current reading, if it did
   typedef enum {READ_NONE, READ_STORED, READ_DROPPED} read_kind_type;

   // receiver back-pressure patterns
   typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_EVERY_THIRD} stall_mode_type;

   logic                 clock     = 1'b0;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   req_type              req_data  = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CFG_WIDTH-1:0] csr_wdata = '0;

   ultrasonic_range_guard_top dut (
      .clock,
      .reset,
      .req_valid,
      .req_stall,
      .req_data,
      .rsp_valid,
      .rsp_stall,
      .rsp_data,
      .csr_valid,
      .csr_ready,
      .csr_index,
      .csr_wdata
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ticks waiting to be offered, and readouts predicted but not yet seen
   req_type tick_q[$];
   rsp_type readout_q[$];

   int   ticks_queued = 0;
   int   fail_count   = 0;
   int   cycle_count  = 0;
   logic req_taken    = 1'b0;

   // sender burst shaping
   int burst_left = 20;
   int gap_left   = 0;

   // receiver pattern and the single long hold-off
   stall_mode_type stall_mode   = STALL_NONE;
   int             mode_left    = 0;
   int             hold_left    = 0;
   logic           hold_request = 1'b0;
   logic           hold_done    = 1'b0;

   // ------------------------------------------------------------------
   // Ranger model: register copy and sequencer state, updated once per
   // accepted tick in the order the hardware is meant to follow.
   // ------------------------------------------------------------------
   cfg_type           cfg;
   phase_type         ph;
   logic [19:0]       ph_ticks;
   logic [19:0]       echo_ticks;   // length of the echo pulse so far
   logic [7:0]        cm_frac;      // ticks into the current centimetre
   logic [10:0]       cm_count;
   logic [9:0]        stored_cm;
   logic              near;
   sweep_type         sweep;
   logic signed [7:0] servo_cmd;

   function automatic int clip(int v, int lo, int hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   // End of a measurement: drop it if over range, else store it, update the
   // near flag and go to the gap (or straight to a new cycle on a zero gap).
   function automatic read_kind_type close_reading();
      ph_ticks = '0;
      if (cm_count > {1'b0, cfg.max_cm}) begin
         ph = PH_START;
         return READ_DROPPED;
      end
      stored_cm = cm_count[9:0];
      near      = (stored_cm <= cfg.threshold_cm);
      if (cfg.gap_ticks == '0) begin
         ph = PH_START;
      end else begin
         ph = PH_GAP;
      end
      return READ_STORED;
   endfunction

   function automatic rsp_type predict_tick(req_type t);
      rsp_type       r;
      read_kind_type kind;
      logic          trig;
      logic [19:0]   tmo;
      logic [7:0]    tpc;
      int            steer;
      int            off;
      int            step;
      int            lim;
      kind  = READ_NONE;
      trig  = 1'b0;
      // zero timeout acts as one tick, zero ticks per cm as one
      tmo   = (cfg.echo_timeout_ticks == '0) ? 20'd1 : cfg.echo_timeout_ticks;
      tpc   = (cfg.ticks_per_cm == '0) ? 8'd1 : cfg.ticks_per_cm;
      steer = $signed(t.steer_angle);

      // cycle start shares its tick with the first trigger-low tick
      if (ph == PH_START) begin
         if (steer == 0 && !near) begin
            step = cfg.sweep_step;
            lim  = cfg.sweep_limit;
            off  = $signed(sweep.offset);
            // offset saturates before the reversal test
            off  = clip(sweep.up ? off + step : off - step, -32, 31);
            sweep.offset = off[5:0];
            if (off >= lim || off <= -lim) sweep.up = ~sweep.up;
            servo_cmd = 8'(off);
         end else begin
            servo_cmd = 8'(clip(steer, -127, 127));
         end
         ph       = PH_TRIG_LOW;
         ph_ticks = '0;
      end

      case (ph)
         PH_TRIG_LOW: begin
            ph_ticks = ph_ticks + 1'b1;
            if (ph_ticks >= TRIG_LOW_TICKS) begin
               ph       = PH_TRIG_HIGH;
               ph_ticks = '0;
            end
         end
         PH_TRIG_HIGH: begin
            trig     = 1'b1;
            ph_ticks = ph_ticks + 1'b1;
            if (ph_ticks >= TRIG_HIGH_TICKS) begin
               ph       = PH_WAIT_RISE;
               ph_ticks = '0;
            end
         end
         PH_WAIT_RISE: begin
            if (t.echo_level) begin
               ph         = PH_MEASURE;
               echo_ticks = '0;
               cm_frac    = '0;
               cm_count   = '0;
            end else begin
               ph_ticks = ph_ticks + 1'b1;
               // echo never came: a zero distance is taken
               if (ph_ticks >= tmo) begin
                  cm_count = '0;
                  kind     = close_reading();
               end
            end
         end
         PH_GAP: begin
            ph_ticks = ph_ticks + 1'b1;
            if (ph_ticks >= cfg.gap_ticks) begin
               ph       = PH_START;
               ph_ticks = '0;
            end
         end
         PH_MEASURE: ;
         default: begin
            ph       = PH_START;
            ph_ticks = '0;
         end
      endcase

      // the rise tick already counts as the first tick of the pulse
      if (ph == PH_MEASURE && kind == READ_NONE) begin
         if (!t.echo_level) begin
            kind = close_reading();
         end else begin
            echo_ticks = echo_ticks + 1'b1;
            cm_frac    = cm_frac + 1'b1;
            if (cm_frac >= tpc) begin
               cm_frac = '0;
               if (cm_count != CM_COUNT_MAX) cm_count = cm_count + 1'b1;
            end
            if (echo_ticks >= tmo) kind = close_reading();
         end
      end

      r.trig_level       = trig;
      r.servo_angle      = servo_cmd;
      r.distance_cm      = stored_cm;
      r.reading_done     = (kind == READ_STORED);
      r.reading_rejected = (kind == READ_DROPPED);
      r.near_flag        = near;
      return r;
   endfunction

   task automatic check_readout(rsp_type want, rsp_type got);
      if (got.trig_level !== want.trig_level || got.servo_angle !== want.servo_angle ||
          got.distance_cm !== want.distance_cm || got.reading_done !== want.reading_done ||
          got.reading_rejected !== want.reading_rejected ||
          got.near_flag !== want.near_flag) begin
         fail_count++;
         if (fail_count <= 10) begin
            $display("readout mismatch: expected trig %b servo %0d dist %0d done %b drop %b near %b",
                     want.trig_level, want.servo_angle, want.distance_cm, want.reading_done,
                     want.reading_rejected, want.near_flag);
            $display("                  actual   trig %b servo %0d dist %0d done %b drop %b near %b",
                     got.trig_level, got.servo_angle, got.distance_cm, got.reading_done,
                     got.reading_rejected, got.near_flag);
         end
      end
   endtask

   // ------------------------------------------------------------------
   // Monitor: everything is sampled at the rising edge. Register writes
   // land in the model copy, readouts are checked against the oldest
   // prediction, and each accepted tick is run through the model.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
         cfg = '{threshold_cm: RST_THRESHOLD_CM, max_cm: RST_MAX_CM,
                 ticks_per_cm: RST_TICKS_PER_CM, echo_timeout_ticks: RST_ECHO_TIMEOUT,
                 gap_ticks: RST_GAP_TICKS, sweep_step: RST_SWEEP_STEP,
                 sweep_limit: RST_SWEEP_LIMIT};
         ph           = PH_START;
         ph_ticks     = '0;
         echo_ticks   = '0;
         cm_frac      = '0;
         cm_count     = '0;
         stored_cm    = '0;
         near         = 1'b0;
         sweep.offset = '0;
         sweep.up     = 1'b1;
         servo_cmd    = '0;
      end else begin
         req_taken <= req_valid && !req_stall;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_THRESHOLD_CM: cfg.threshold_cm       = csr_wdata[9:0];
               CSR_MAX_CM:       cfg.max_cm             = csr_wdata[9:0];
               CSR_TICKS_PER_CM: cfg.ticks_per_cm       = csr_wdata[7:0];
               CSR_ECHO_TIMEOUT: cfg.echo_timeout_ticks = csr_wdata[19:0];
               CSR_GAP_TICKS:    cfg.gap_ticks          = csr_wdata[19:0];
               CSR_SWEEP_STEP:   cfg.sweep_step         = csr_wdata[3:0];
               CSR_SWEEP_LIMIT:  cfg.sweep_limit        = csr_wdata[4:0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (readout_q.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("readout with nothing pending: trig %b servo %0d dist %0d",
                           rsp_data.trig_level, rsp_data.servo_angle, rsp_data.distance_cm);
            end else begin
               check_readout(readout_q.pop_front(), rsp_data);
            end
         end
         if (req_valid && !req_stall) readout_q.push_back(predict_tick(req_data));
      end
   end

   // ------------------------------------------------------------------
   // Sender: offers queued ticks in bursts of random length with random
   // gaps. A stalled item is held untouched until it is taken.
   // ------------------------------------------------------------------
   always @(negedge clock) begin : sender
      logic offer;
      if (!reset && (!req_valid || req_taken)) begin
         offer = 1'b0;
         if (gap_left > 0) begin
            gap_left--;
         end else if (tick_q.size() != 0) begin
            req_data <= tick_q.pop_front();
            offer = 1'b1;
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 60);
               // about a third of bursts run straight into the next
               gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            end
         end
         req_valid <= offer;
      end
   end

   // ------------------------------------------------------------------
   // Receiver: a random back-pressure pattern that changes at random,
   // plus one long hold-off so the block backs up and stalls its input.
   // ------------------------------------------------------------------
   always @(negedge clock) begin : receiver
      logic hold;
      if (hold_left > 0) begin
         hold = 1'b1;
         hold_left--;
      end else if (hold_request && !hold_done) begin
         hold      = 1'b1;
         hold_done = 1'b1;
         hold_left = HOLD_OFF_CYCLES - 1;
      end else begin
         if (mode_left == 0) begin
            stall_mode = stall_mode_type'($urandom_range(0, 3));
            mode_left  = $urandom_range(10, 80);
         end
         mode_left--;
         case (stall_mode)
            STALL_NONE:  hold = 1'b0;
            STALL_LIGHT: hold = ($urandom_range(0, 3) == 0);
            STALL_HEAVY: hold = ($urandom_range(0, 9) < 7);
            default:     hold = (cycle_count % 3 == 0);
         endcase
      end
      rsp_stall <= hold;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[ultrasonic_range_guard_top] ERROR");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------
   task automatic push_tick(logic echo, logic signed [7:0] steer);
      req_type t;
      t.echo_level  = echo;
      t.steer_angle = steer;
      tick_q.push_back(t);
      ticks_queued++;
   endtask

   // mostly straight ahead so the sweep runs, otherwise anything the field holds
   function automatic logic signed [7:0] pick_steer();
      case ($urandom_range(0, 9))
         6:       return 8'($urandom_range(0, 255));
         7:       return ($urandom_range(0, 1) == 0) ? -8'sd128 : 8'sd127;
         8, 9:    return 8'($urandom_range(0, 180) - 90);
         default: return 8'sd0;
      endcase
   endfunction

   task automatic push_ticks(logic echo, int n);
      repeat (n) push_tick(echo, pick_steer());
   endtask

   // nothing left to offer and every predicted readout seen
   task automatic wait_idle();
      do @(posedge clock);
      while (tick_q.size() != 0 || req_valid || readout_q.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CFG_WIDTH-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock);
      while (!csr_ready);
   endtask

   // every register, with junk above each narrower field, then the unused index
   task automatic apply_settings(cfg_type c);
      write_reg(CSR_THRESHOLD_CM, {10'($urandom), c.threshold_cm});
      write_reg(CSR_MAX_CM,       {10'($urandom), c.max_cm});
      write_reg(CSR_TICKS_PER_CM, {12'($urandom), c.ticks_per_cm});
      write_reg(CSR_ECHO_TIMEOUT, c.echo_timeout_ticks);
      write_reg(CSR_GAP_TICKS,    c.gap_ticks);
      write_reg(CSR_SWEEP_STEP,   {16'($urandom), c.sweep_step});
      write_reg(CSR_SWEEP_LIMIT,  {15'($urandom), c.sweep_limit});
      write_reg(CSR_SPARE,        20'($urandom));
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic cfg_type make_cfg(int thr, int max, int tpc, int tmo, int gap,
                                        int step, int lim);
      cfg_type c;
      c.threshold_cm       = 10'(thr);
      c.max_cm             = 10'(max);
      c.ticks_per_cm       = 8'(tpc);
      c.echo_timeout_ticks = 20'(tmo);
      c.gap_ticks          = 20'(gap);
      c.sweep_step         = 4'(step);
      c.sweep_limit        = 5'(lim);
      return c;
   endfunction

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      cfg_type c;
      int      cap;
      int      base;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: reset settings, steering extremes while the trigger runs.
      push_tick(1'b0, 8'sd0);
      push_tick(1'b1, -8'sd128);
      push_tick(1'b0, 8'sd127);
      push_tick(1'b1, -8'sd90);
      push_tick(1'b0, 8'sd90);
      push_tick(1'b1, -8'sd1);
      push_tick(1'b0, 8'sd1);
      push_tick(1'b1, 8'sd64);
      push_tick(1'b0, -8'sd64);
      push_tick(1'b1, 8'sd0);
      wait_idle();

      // Zero timeout, zero ticks per cm, zero gap, zero threshold: the wait
      // for echo gives up at once, distance 0 is stored and sets near, and
      // the next cycle takes the plain angle (-128 clipped to -127).
      apply_settings(make_cfg(0, 1023, 0, 0, 0, 15, 31));
      repeat (12) push_tick(1'b0, 8'sd0);
      push_tick(1'b0, 8'sd0);
      push_tick(1'b0, -8'sd128);
      push_tick(1'b1, 8'sd127);
      push_tick(1'b0, 8'sd0);
      push_tick(1'b1, 8'sd0);
      wait_idle();

      // Random part: a run of settings, mostly trigger-wait-pulse episodes
      // with random lead and width, the rest noise and odd lengths.
      for (int p = 0; p < 8; p++) begin
         case (p)
            0: begin c = make_cfg(0,    1023, 1,   40,      5,       15, 31); cap = 60;  end
            1: begin c = make_cfg(1023, 1023, 3,   60,      0,       5,  10); cap = 80;  end
            2: begin c = make_cfg(0,    0,    2,   30,      1048575, 0,  0);  cap = 40;  end
            3: begin c = make_cfg(200,  100,  0,   1048575, 3,       7,  20); cap = 60;  end
            4: begin c = make_cfg(10,   20,   2,   50,      10,      3,  5);  cap = 60;  end
            5: begin c = make_cfg(1,    1023, 255, 1000,    0,       15, 1);  cap = 300; end
            6: begin c = make_cfg(5,    30,   1,   1,       2,       1,  0);  cap = 5;   end
            default: begin c = make_cfg(40, 1000, 58, 200, 20, 5, 10); cap = 250; end
         endcase
         apply_settings(c);
         base = ticks_queued;
         while (ticks_queued - base < 80) begin
            case ($urandom_range(0, 9))
               7: repeat ($urandom_range(1, 20)) push_tick(1'($urandom_range(0, 1)), pick_steer());
               8: push_ticks(1'b0, $urandom_range(0, 80));
               9: push_ticks(1'b1, $urandom_range(1, 2 * cap));
               default: begin
                  push_ticks(1'b0, $urandom_range(0, 60));
                  push_ticks(1'b1, $urandom_range(1, cap));
               end
            endcase
         end
         if (p == 3) begin
            // unit ticks per cm and the longest timeout: a pulse one
            // centimetre over range, then one exactly at the range limit
            push_ticks(1'b0, 40);
            push_ticks(1'b1, 101);
            push_ticks(1'b0, 40);
            push_ticks(1'b1, 100);
            push_ticks(1'b0, 5);
            // plenty queued, so the sender keeps offering through the hold-off
            hold_request = 1'b1;
         end
         wait_idle();
      end

      repeat (8) @(posedge clock);
      if (fail_count == 0 && readout_q.size() == 0) begin
         $display("[ultrasonic_range_guard_top] OK");
      end else begin
         $display("[ultrasonic_range_guard_top] ERROR");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/urg_pkg.sv
rtl/urg_servo.sv
rtl/urg_step.sv
rtl/ultrasonic_range_guard_top.sv
rtl/urg_checker.sv
bench/ultrasonic_range_guard_top_test.sv
